// ----- hdl/mscfc_pkg.sv -----
// shared types, constants and the crc-16/modbus byte update for the frame checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mscfc_pkg;

    localparam logic [15:0] CRC_INIT           = 16'hFFFF;
    localparam logic [15:0] CRC_POLY           = 16'hA001;
    localparam logic [7:0]  HDR_NO_SLAVE_CHECK = 8'h1E;
    localparam logic [7:0]  HDR_NONZERO_SLAVE  = 8'h3E;
    localparam logic [8:0]  MIN_FRAME          = 9'd6;
    localparam logic [8:0]  LEN_OVERHEAD       = 9'd5;
    localparam logic [8:0]  COUNT_MAX          = 9'd511;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CRC      = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_HEADER   = 3'd3;
    localparam logic [2:0] ST_FUNCTION = 3'd4;
    localparam logic [2:0] ST_SLAVE    = 3'd5;
    localparam logic [2:0] ST_ZERO     = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_EXP_HEADER   = 2'd0;
    localparam logic [1:0] REG_EXP_FUNCTION = 2'd1;
    localparam logic [1:0] REG_EXP_SLAVE    = 2'd2;

    // one finished frame, as handed from front to back
    typedef struct packed {
        logic        bad_crc;
        logic [7:0]  hdr;
        logic [7:0]  func;
        logic [7:0]  len;
        logic [7:0]  slave;
        logic [15:0] crc;
        logic [8:0]  count;
    } frame_rec_t;

    typedef struct packed {
        logic [7:0] exp_header;
        logic [7:0] exp_function;
        logic [7:0] exp_slave;
    } cfg_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/modbus_style_frame_checker_unit.sv -----
// modbus-style reply frame checker, top level: stream ports, apb registers
// depends on mscfc_pkg, mscfc_front, mscfc_queue, mscfc_back
//
// usage
//  - s_axis carries one received reply byte per transaction: tdata[7:0] is the
//    byte, tlast marks the final byte of the frame
//  - m_axis carries one result per frame, issued for the transaction with tlast
//  - apb registers: 0x0 expected header, 0x4 expected function, 0x8 expected slave
//  - throughput: one byte per cycle while the record queue is not full; the
//    crc-16/modbus byte update is a combinational unrolled step in the front part
//  - the result passes through the record queue and then the classifier output
//    register before it shows on m_axis
//  - a stalled m_axis receiver lets results pile up in the record queue; the
//    front keeps taking bytes until the queue is full, then drops s_axis_tready
//  - reset clears the crc, byte counter, captured fields, queue and output
//    valid; the expected-value registers reset to zero
//
`timescale 1ns / 1ps
`default_nettype none

module modbus_style_frame_checker_unit
    import mscfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave-side stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // last_byte
    // master-side stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] status, [10:3] got_header, [18:11] got_function,
    // [26:19] got_length, [34:27] got_slave, [50:35] got_crc,
    // [59:51] frame_bytes, [63:60] zero
    output logic [63:0]      m_axis_tdata,
    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic       push;
    frame_rec_t push_rec;
    logic       queue_full;
    logic       pop;
    logic       head_valid;
    frame_rec_t head_rec;
    logic [2:0] res_status;
    frame_rec_t res_rec;

    // apb register file, writes take effect on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_EXP_HEADER:   cfg_reg.exp_header   <= pwdata[7:0];
                REG_EXP_FUNCTION: cfg_reg.exp_function <= pwdata[7:0];
                REG_EXP_SLAVE:    cfg_reg.exp_slave    <= pwdata[7:0];
                default:          ;   // unmapped address, write ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_EXP_HEADER:   prdata = {24'h0, cfg_reg.exp_header};
            REG_EXP_FUNCTION: prdata = {24'h0, cfg_reg.exp_function};
            REG_EXP_SLAVE:    prdata = {24'h0, cfg_reg.exp_slave};
            default:          prdata = 32'h0;
        endcase
    end

    // byte intake, crc and header capture
    mscfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .byte_data  (s_axis_tdata),
        .byte_last  (s_axis_tlast),
        .push       (push),
        .push_rec   (push_rec),
        .queue_full (queue_full)
    );

    // decouples the byte side from the result side
    mscfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // frame classification and output register
    mscfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_status (res_status),
        .res_rec    (res_rec)
    );

    assign m_axis_tdata = {4'h0, res_rec.count, res_rec.crc, res_rec.slave,
                           res_rec.len, res_rec.func, res_rec.hdr, res_status};

endmodule

`default_nettype wire

// ----- hdl/mscfc_front.sv -----
// front part: takes frame bytes, runs the crc and captures header fields
// depends on mscfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mscfc_front
    import mscfc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire logic [7:0] byte_data,
    input  wire logic       byte_last,
    output logic            push,
    output frame_rec_t      push_rec,
    input  wire logic       queue_full
);

    logic [15:0] crc_reg, crc_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  d0_reg, d0_next;
    logic [7:0]  d1_reg, d1_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  slave_reg, slave_next;
    logic        take;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;

    assign byte_ready = !queue_full;
    assign take       = byte_valid && byte_ready;

    always_comb
    begin
        crc_upd    = (count_reg >= 9'd2) ? crc_byte(crc_reg, d1_reg) : crc_reg;
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 9'd1;
        hdr_next   = (count_reg == 9'd0) ? byte_data : hdr_reg;
        func_next  = (count_reg == 9'd1) ? byte_data : func_reg;
        len_next   = (count_reg == 9'd2) ? byte_data : len_reg;
        slave_next = (count_reg == 9'd3) ? byte_data : slave_reg;
        rx_crc     = {byte_data, d0_reg};
        crc_next   = crc_upd;
        d0_next    = byte_data;
        d1_next    = d0_reg;

        push_rec.bad_crc = (count_next < MIN_FRAME) || (crc_upd != rx_crc);
        push_rec.hdr     = hdr_next;
        push_rec.func    = func_next;
        push_rec.len     = len_next;
        push_rec.slave   = slave_next;
        push_rec.crc     = rx_crc;
        push_rec.count   = count_next;
        push             = take && byte_last;

        // frame end: back to the start state
        if (byte_last)
        begin
            crc_next   = CRC_INIT;
            count_next = 9'd0;
            d0_next    = 8'h00;
            d1_next    = 8'h00;
            hdr_next   = 8'h00;
            func_next  = 8'h00;
            len_next   = 8'h00;
            slave_next = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            count_reg <= 9'd0;
            d0_reg    <= 8'h00;
            d1_reg    <= 8'h00;
            hdr_reg   <= 8'h00;
            func_reg  <= 8'h00;
            len_reg   <= 8'h00;
            slave_reg <= 8'h00;
        end
        else if (take)
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            d0_reg    <= d0_next;
            d1_reg    <= d1_next;
            hdr_reg   <= hdr_next;
            func_reg  <= func_next;
            len_reg   <= len_next;
            slave_reg <= slave_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/mscfc_queue.sv -----
// short queue of finished frame records between front and back
// depends on mscfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mscfc_queue
    import mscfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire frame_rec_t push_rec,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output frame_rec_t      head_rec
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_rec_t          mem_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

// ----- hdl/mscfc_back.sv -----
// back part: classifies a frame record against the expected values and
// holds the result in the output register; depends on mscfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mscfc_back
    import mscfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        head_valid,
    input  wire frame_rec_t  head_rec,
    output logic             pop,
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic [2:0]       res_status,
    output frame_rec_t       res_rec
);

    logic       valid_reg, valid_next;
    logic [2:0] status_reg, status_next;
    frame_rec_t rec_reg;
    logic [8:0] want_count;

    assign pop        = head_valid && (!valid_reg || res_ready);
    assign res_valid  = valid_reg;
    assign res_status = status_reg;
    assign res_rec    = rec_reg;

    always_comb
    begin
        want_count = LEN_OVERHEAD + {1'b0, head_rec.len};
        if (head_rec.bad_crc)
            status_next = ST_CRC;
        else if (head_rec.count != want_count)
            status_next = ST_LENGTH;
        else if (head_rec.hdr != cfg.exp_header)
            status_next = ST_HEADER;
        else if (head_rec.func != cfg.exp_function)
            status_next = ST_FUNCTION;
        else if (cfg.exp_header != HDR_NO_SLAVE_CHECK && head_rec.slave != cfg.exp_slave)
            status_next = ST_SLAVE;
        else if (cfg.exp_header == HDR_NONZERO_SLAVE && head_rec.slave == 8'h00)
            status_next = ST_ZERO;
        else
            status_next = ST_OK;

        if (pop)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= status_next;
            rec_reg    <= head_rec;
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_modbus_style_frame_checker_unit.sv -----
// testbench for the modbus-style reply frame checker: directed table, then random frames
// with random idling on both streams, checked against a local frame-check predictor
// depends on mscfc_pkg and modbus_style_frame_checker_unit
`timescale 1ns / 1ps

module tb_modbus_style_frame_checker_unit;
    import mscfc_pkg::*;

    localparam int          ITEM_TARGET     = 1250;
    localparam int          HOLD_OFF_CYCLES = 150;
    localparam int          QUIET_LIMIT     = 1000;
    localparam int          SETTLE_CYCLES   = 4;
    localparam logic [3:0]  ADDR_UNUSED     = 4'hC;   // register index 3, writes are dropped

    // one frame verdict as carried on m_axis
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  hdr;
        logic [7:0]  func;
        logic [7:0]  len;
        logic [7:0]  slave;
        logic [15:0] crc;
        logic [8:0]  count;
    } frame_verdict_t;

    typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_CFG} row_kind_e;

    // one line of the directed table
    typedef struct packed {
        row_kind_e      kind;
        logic [3:0]     addr;
        logic [7:0]     val;
        logic           last;
        logic           typed;
        frame_verdict_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] rx_byte
    logic        s_axis_tlast;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [2:0] status, [10:3] got_header, [18:11] got_function, [26:19] got_length,
    // [34:27] got_slave, [50:35] got_crc, [59:51] frame_bytes, [63:60] zero
    logic [63:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the block
    logic [7:0]  exp_hdr, exp_func, exp_slave;
    logic [15:0] acc_crc;
    logic [8:0]  acc_count;
    logic [7:0]  acc_prev0, acc_prev1;
    logic [7:0]  cap_hdr, cap_func, cap_len, cap_slave;

    frame_verdict_t verdicts_due[$];
    logic [15:0]    tx_crc;          // crc of the bytes sent so far in the current frame
    int             items_sent;
    int             fail_count;
    int             quiet_cycles;
    bit             no_gaps;
    bit             hold_off_req;

    modbus_style_frame_checker_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 clk = ~clk;

    // reflected crc-16 step, one byte, lsb first
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic stim_row_t mk_row(input row_kind_e kind, input logic [3:0] addr,
                                         input logic [7:0] val, input logic last,
                                         input logic typed, input frame_verdict_t want);
        stim_row_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.val   = val;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [7:0] pick_byte(input logic [7:0] hit, input int pct);
        if ($urandom_range(0, 99) < pct)
            return hit;
        return 8'($urandom_range(0, 255));
    endfunction

    // extremes and the two special header codes show up often
    function automatic logic [7:0] pick_cfg(input bit is_header);
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        if (is_header && r == 2)
            return HDR_NO_SLAVE_CHECK;
        if (is_header && r == 3)
            return HDR_NONZERO_SLAVE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic clear_frame();
        acc_crc   = CRC_INIT;
        acc_count = '0;
        acc_prev0 = '0;
        acc_prev1 = '0;
        cap_hdr   = '0;
        cap_func  = '0;
        cap_len   = '0;
        cap_slave = '0;
    endtask

    // advance the frame checker copy by one byte; a final byte yields a verdict
    task automatic checker_take_byte(input logic [7:0] b, input logic last,
                                     output bit done, output frame_verdict_t v);
        logic [15:0] rx_crc;
        logic [2:0]  st;
        done = 1'b0;
        v    = '0;
        // crc runs two bytes behind so the trailing crc bytes never enter it
        if (acc_count >= 9'd2)
            acc_crc = crc_step(acc_crc, acc_prev1);
        case (acc_count)
            9'd0: cap_hdr   = b;
            9'd1: cap_func  = b;
            9'd2: cap_len   = b;
            9'd3: cap_slave = b;
            default: ;
        endcase
        acc_prev1 = acc_prev0;
        acc_prev0 = b;
        if (acc_count != COUNT_MAX)
            acc_count = acc_count + 9'd1;
        if (last)
        begin
            rx_crc = {acc_prev0, acc_prev1};
            if (acc_count < MIN_FRAME || acc_crc != rx_crc)
                st = ST_CRC;
            else if (acc_count != LEN_OVERHEAD + {1'b0, cap_len})
                st = ST_LENGTH;
            else if (cap_hdr != exp_hdr)
                st = ST_HEADER;
            else if (cap_func != exp_func)
                st = ST_FUNCTION;
            else if (exp_hdr != HDR_NO_SLAVE_CHECK && cap_slave != exp_slave)
                st = ST_SLAVE;
            else if (exp_hdr == HDR_NONZERO_SLAVE && cap_slave == 8'h00)
                st = ST_ZERO;
            else
                st = ST_OK;
            v.status = st;
            v.hdr    = cap_hdr;
            v.func   = cap_func;
            v.len    = cap_len;
            v.slave  = cap_slave;
            v.crc    = rx_crc;
            v.count  = acc_count;
            done     = 1'b1;
            clear_frame();
        end
    endtask

    // offer one byte after a random gap, predict at the accepting edge
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic typed = 1'b0, input frame_verdict_t want = '0);
        int             gap;
        bit             done;
        frame_verdict_t v;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        checker_take_byte(b, last, done, v);
        if (done)
            verdicts_due.push_back(typed ? want : v);
        tx_crc = last ? CRC_INIT : crc_step(tx_crc, b);
        items_sent++;
    endtask

    // stop offering and let every outstanding verdict drain
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup then access, upper data bits are noise the block must ignore
    task automatic reg_write(input logic [3:0] addr, input logic [7:0] val);
        logic [31:0] word;
        word      = $urandom;
        word[7:0] = val;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (addr[3:2])
            REG_EXP_HEADER:   exp_hdr   = val;
            REG_EXP_FUNCTION: exp_func  = val;
            REG_EXP_SLAVE:    exp_slave = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] func,
                              input logic [7:0] len, input logic [7:0] slave,
                              input int ndata, input bit crc_ok);
        logic [15:0] c;
        send_byte(hdr, 1'b0);
        send_byte(func, 1'b0);
        send_byte(len, 1'b0);
        send_byte(slave, 1'b0);
        repeat (ndata) send_byte(8'($urandom_range(0, 255)), 1'b0);
        c = tx_crc;
        if (!crc_ok)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        send_byte(c[7:0], 1'b0);
        send_byte(c[15:8], 1'b1);
    endtask

    task automatic send_random_frame();
        int          kind;
        int          n;
        logic [7:0]  len;
        logic [7:0]  slave;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 70)
            slave = exp_slave;
        else if ($urandom_range(0, 1) == 0)
            slave = 8'h00;
        else
            slave = 8'($urandom_range(0, 255));
        if (kind < 60)
        begin
            // well formed: length field agrees with the byte count
            len = 8'($urandom_range(1, 8));
            send_frame(pick_byte(exp_hdr, 85), pick_byte(exp_func, 85), len, slave,
                       int'(len) - 1, $urandom_range(0, 9) != 0);
        end
        else if (kind < 80)
        begin
            send_frame(pick_byte(exp_hdr, 85), pick_byte(exp_func, 85),
                       8'($urandom_range(0, 255)), slave, $urandom_range(0, 8),
                       $urandom_range(0, 9) != 0);
        end
        else
        begin
            // short frames and plain noise
            n = (kind < 95) ? $urandom_range(1, 5) : $urandom_range(1, 20);
            repeat (n - 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // result side: compare every accepted transaction with the oldest verdict
    always @(posedge clk)
    begin
        frame_verdict_t w;
        if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("unexpected result transaction %0h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                w = verdicts_due.pop_front();
                check_field("status",       16'(w.status), 16'(m_axis_tdata[2:0]));
                check_field("got_header",   16'(w.hdr),    16'(m_axis_tdata[10:3]));
                check_field("got_function", 16'(w.func),   16'(m_axis_tdata[18:11]));
                check_field("got_length",   16'(w.len),    16'(m_axis_tdata[26:19]));
                check_field("got_slave",    16'(w.slave),  16'(m_axis_tdata[34:27]));
                check_field("got_crc",      w.crc,         m_axis_tdata[50:35]);
                check_field("frame_bytes",  16'(w.count),  16'(m_axis_tdata[59:51]));
                check_field("pad",          16'h0000,      16'(m_axis_tdata[63:60]));
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                stall        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else
                stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1);
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) || psel === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        stim_row_t      dir_rows[$];
        stim_row_t      row;
        frame_verdict_t want;
        logic [15:0]    crc_hold;
        int             phase;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        exp_hdr       = '0;
        exp_func      = '0;
        exp_slave     = '0;
        tx_crc        = CRC_INIT;
        items_sent    = 0;
        fail_count    = 0;
        quiet_cycles  = 0;
        no_gaps       = 1'b0;
        hold_off_req  = 1'b0;
        crc_hold      = '0;
        clear_frame();

        // directed table
        // single-byte frame: fields of missing bytes read zero
        want = '{status: ST_CRC, hdr: 8'hFF, func: 8'h00, len: 8'h00, slave: 8'h00,
                 crc: 16'hFF00, count: 9'd1};
        dir_rows.push_back(mk_row(ROW_BYTE, 4'h0, 8'hFF, 1'b1, 1'b1, want));
        // two-byte frame: both crc halves come from the two bytes
        want = '{status: ST_CRC, hdr: 8'h00, func: 8'hFF, len: 8'h00, slave: 8'h00,
                 crc: 16'hFF00, count: 9'd2};
        dir_rows.push_back(mk_row(ROW_BYTE, 4'h0, 8'h00, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE, 4'h0, 8'hFF, 1'b1, 1'b1, want));
        // shortest well-formed frame against the reset register values
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'h00, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'h00, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'h01, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'h00, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CRC_LO, 4'h0, 8'h00, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CRC_HI, 4'h0, 8'h00, 1'b1, 1'b0, '0));
        // header 0x3e with a zero slave id is refused
        dir_rows.push_back(mk_row(ROW_CFG, {REG_EXP_HEADER, 2'b00}, HDR_NONZERO_SLAVE,
                                  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, {REG_EXP_FUNCTION, 2'b00}, 8'hFF,
                                  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, HDR_NONZERO_SLAVE, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'hFF, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'h01, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'h00, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CRC_LO, 4'h0, 8'h00, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CRC_HI, 4'h0, 8'h00, 1'b1, 1'b0, '0));
        // write past the last register is dropped, then header 0x1e skips the slave compare
        dir_rows.push_back(mk_row(ROW_CFG, ADDR_UNUSED, 8'h5A, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, {REG_EXP_HEADER, 2'b00}, HDR_NO_SLAVE_CHECK,
                                  1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CFG, {REG_EXP_SLAVE, 2'b00}, 8'hFF, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, HDR_NO_SLAVE_CHECK, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'hFF, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'h01, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_BYTE,   4'h0, 8'h7A, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CRC_LO, 4'h0, 8'h00, 1'b0, 1'b0, '0));
        dir_rows.push_back(mk_row(ROW_CRC_HI, 4'h0, 8'h00, 1'b1, 1'b0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            case (row.kind)
                ROW_CFG:
                begin
                    settle_idle();
                    reg_write(row.addr, row.val);
                end
                ROW_CRC_LO:
                begin
                    crc_hold = tx_crc;
                    send_byte(crc_hold[7:0], row.last);
                end
                ROW_CRC_HI:
                    send_byte(crc_hold[15:8], row.last);
                default:
                    send_byte(row.val, row.last, row.typed, row.want);
            endcase
        end

        // random phases, each under its own register setting
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle_idle();
            reg_write({REG_EXP_HEADER, 2'b00},   pick_cfg(1'b1));
            reg_write({REG_EXP_FUNCTION, 2'b00}, pick_cfg(1'b0));
            reg_write({REG_EXP_SLAVE, 2'b00},    pick_cfg(1'b0));
            if ($urandom_range(0, 3) == 0)
                reg_write(ADDR_UNUSED, 8'($urandom_range(0, 255)));
            no_gaps = ($urandom_range(0, 3) == 0);
            // long receiver hold-off while frames keep coming back to back,
            // fills the record queue and stalls the byte side
            if (phase == 0)
            begin
                no_gaps      = 1'b1;
                hold_off_req = 1'b1;
            end
            // largest length field, correct count and crc
            if (phase == 1)
                send_frame(exp_hdr, exp_func, 8'd255, exp_slave, 254, 1'b1);
            // byte counter runs up to or into saturation
            if (phase == 3)
                send_frame(pick_byte(exp_hdr, 50), pick_byte(exp_func, 50),
                           8'($urandom_range(0, 255)), exp_slave,
                           $urandom_range(504, 530), 1'b1);
            repeat (8) send_random_frame();
            phase++;
        end

        settle_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
